// File: hdl/capst_pkg.sv
package capst_pkg;

  localparam int unsigned SLOT_COUNT  = 64;
  localparam int unsigned SLOT_W      = $clog2(SLOT_COUNT);
  localparam int unsigned COUNT_W     = $clog2(SLOT_COUNT + 1);
  localparam int unsigned IDX_W       = 7;
  localparam int unsigned GEN_BITS    = 16;
  localparam int unsigned TAG_BITS    = 16;
  localparam int unsigned RIGHTS_BITS = 8;
  localparam int unsigned KIND_W      = 4;
  localparam int unsigned SPACE_W     = 16;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned STATUS_W    = 4;
  localparam int unsigned APB_AW      = 3;
  localparam int unsigned APB_DW      = 32;

  localparam logic [RIGHTS_BITS-1:0] RIGHT_GRANT_BIT = RIGHTS_BITS'(1);

  typedef enum logic [OP_W-1:0] {
    OP_INSTALL     = 3'd0,
    OP_REMOVE      = 3'd1,
    OP_LOOKUP      = 3'd2,
    OP_CLEAR_GRANT = 3'd3,
    OP_REVOKE      = 3'd4,
    OP_PEEK        = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 4'd0,
    STAT_BAD_INDEX   = 4'd1,
    STAT_WRONG_SPACE = 4'd2,
    STAT_EMPTY       = 4'd3,
    STAT_STALE       = 4'd4,
    STAT_WRONG_TYPE  = 4'd5,
    STAT_RIGHTS      = 4'd6,
    STAT_DEAD        = 4'd7,
    STAT_FULL        = 4'd8
  } status_e;

  typedef enum logic {
    REG_SPACE_ID   = 1'b0,
    REG_GRANT_MASK = 1'b1
  } reg_e;

  typedef struct packed {
    logic [TAG_BITS-1:0]    tag;
    logic [KIND_W-1:0]      kind;
    logic [RIGHTS_BITS-1:0] rights;
    logic [GEN_BITS-1:0]    gen;
  } slot_entry_t;

endpackage

// File: hdl/capability_slot_table_top.sv
// channel | direction | handshake                | payload
// in      | input     | in_valid_i / in_stall_o   | op, index, handle, tag, kind, rights, live
// out     | output    | out_valid_o / out_stall_i | status, slot, object, generation, used slots
// cfg     | input     | psel / penable / pready   | space_id at 0x0, grant_mask at 0x4
//
// each beat reads the slot memory when it is accepted, then checks and writes back in the execute state
// the slot memory has one port for reads and one for writes, read data registered
// occupancy and per-slot written bits are flops; reset clears them at once, no clearing pass
// a result waits in the output register while the next beat is taken in
// a beat stays in the execute cycle while an earlier result is stalled at the output
module capability_slot_table_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [capst_pkg::OP_W-1:0]          op_i,
  input  logic [capst_pkg::IDX_W-1:0]         slot_index_i,
  input  logic [capst_pkg::SPACE_W-1:0]       handle_space_i,
  input  logic [capst_pkg::GEN_BITS-1:0]      handle_generation_i,
  input  logic [capst_pkg::TAG_BITS-1:0]      object_tag_i,
  input  logic [capst_pkg::KIND_W-1:0]        cap_kind_i,
  input  logic [capst_pkg::RIGHTS_BITS-1:0]   rights_bits_i,
  input  logic                                object_live_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [capst_pkg::STATUS_W-1:0]      status_o,
  output logic [capst_pkg::SLOT_W-1:0]        slot_out_o,
  output logic [capst_pkg::TAG_BITS-1:0]      object_out_o,
  output logic [capst_pkg::GEN_BITS-1:0]      generation_out_o,
  output logic [capst_pkg::COUNT_W-1:0]       used_slots_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [capst_pkg::APB_AW-1:0]        paddr,
  input  logic [capst_pkg::APB_DW-1:0]        pwdata,
  output logic [capst_pkg::APB_DW-1:0]        prdata,
  output logic                                pready
);
  import capst_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                   state_q, state_d;
  logic [SPACE_W-1:0]     space_id_q;
  logic [RIGHTS_BITS-1:0] grant_mask_q;

  logic [SLOT_COUNT-1:0]  used_q, used_d;
  logic [SLOT_COUNT-1:0]  written_q;
  logic [COUNT_W-1:0]     cnt_q, cnt_d;

  slot_entry_t            mem [SLOT_COUNT];
  slot_entry_t            rd_q;
  logic                   rd_hit_q;

  logic [OP_W-1:0]        op_q;
  logic [IDX_W-1:0]       idx_q;
  logic [SPACE_W-1:0]     hspace_q;
  logic [GEN_BITS-1:0]    hgen_q;
  logic [TAG_BITS-1:0]    tag_q;
  logic [KIND_W-1:0]      kind_q;
  logic [RIGHTS_BITS-1:0] rights_q;
  logic                   live_q;
  logic [SLOT_W-1:0]      free_idx_q;
  logic                   full_q;

  logic [SLOT_W-1:0]      free_idx;
  logic                   full;
  logic [SLOT_W-1:0]      rd_addr;
  logic                   in_acc;
  logic                   exec_go;
  logic                   cfg_wr;

  slot_entry_t            ent;
  slot_entry_t            wr_data;
  logic                   wr_en;
  logic [SLOT_W-1:0]      slot_a;
  logic                   idx_ok;
  logic                   slot_used;
  logic                   is_handle;
  status_e                status;
  logic [SLOT_W-1:0]      res_slot;
  logic [TAG_BITS-1:0]    res_obj;
  logic [GEN_BITS-1:0]    res_gen;

  logic                   out_valid_q;
  logic [STATUS_W-1:0]    status_q;
  logic [SLOT_W-1:0]      slot_out_q;
  logic [TAG_BITS-1:0]    object_out_q;
  logic [GEN_BITS-1:0]    generation_out_q;
  logic [COUNT_W-1:0]     used_slots_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign exec_go    = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  // lowest free slot
  always_comb begin
    free_idx = '0;
    full     = 1'b1;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = SLOT_W'(i);
        full     = 1'b0;
      end
    end
  end

  assign rd_addr = (op_i == OP_INSTALL) ? free_idx : slot_index_i[SLOT_W-1:0];

  // apb
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_e'(paddr[2]))
      REG_SPACE_ID:   prdata = APB_DW'(space_id_q);
      REG_GRANT_MASK: prdata = APB_DW'(grant_mask_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      space_id_q   <= '0;
      grant_mask_q <= RIGHT_GRANT_BIT;
    end else if (cfg_wr) begin
      unique case (reg_e'(paddr[2]))
        REG_SPACE_ID:   space_id_q   <= pwdata[SPACE_W-1:0];
        REG_GRANT_MASK: grant_mask_q <= pwdata[RIGHTS_BITS-1:0];
        default:        ;
      endcase
    end
  end

  // check and write back
  always_comb begin
    ent       = rd_hit_q ? rd_q : '0;
    slot_a    = (op_q == OP_INSTALL) ? free_idx_q : idx_q[SLOT_W-1:0];
    idx_ok    = idx_q < IDX_W'(SLOT_COUNT);
    slot_used = used_q[slot_a];
    is_handle = (op_q == OP_LOOKUP) || (op_q == OP_REVOKE);
    status    = STAT_OK;
    res_slot  = '0;
    res_obj   = '0;
    res_gen   = '0;
    wr_en     = 1'b0;
    wr_data   = ent;
    used_d    = used_q;
    cnt_d     = cnt_q;

    if (op_q == OP_INSTALL) begin
      priority if (kind_q == '0) begin
        status = STAT_WRONG_TYPE;
      end else if (!live_q) begin
        status = STAT_DEAD;
      end else if (full_q) begin
        status = STAT_FULL;
      end else begin
        wr_en          = 1'b1;
        wr_data.tag    = tag_q;
        wr_data.kind   = kind_q;
        wr_data.rights = rights_q;
        used_d[slot_a] = 1'b1;
        cnt_d          = cnt_q + COUNT_W'(1);
        res_slot       = slot_a;
        res_gen        = ent.gen;
      end
    end else if (op_q == OP_REMOVE || op_q == OP_LOOKUP || op_q == OP_CLEAR_GRANT ||
                 op_q == OP_REVOKE || op_q == OP_PEEK) begin
      if (!idx_ok) begin
        status = STAT_BAD_INDEX;
      end else begin
        res_slot = slot_a;
        res_gen  = ent.gen;
        priority if (is_handle && hspace_q != space_id_q) begin
          status = STAT_WRONG_SPACE;
        end else if (!slot_used) begin
          status = STAT_EMPTY;
        end else if (is_handle && hgen_q != ent.gen) begin
          status = STAT_STALE;
        end else if ((op_q == OP_LOOKUP || op_q == OP_PEEK) && ent.kind != kind_q) begin
          status = STAT_WRONG_TYPE;
        end else if (op_q == OP_LOOKUP && (ent.rights & rights_q) != rights_q) begin
          status = STAT_RIGHTS;
        end else if (op_q == OP_LOOKUP && !live_q) begin
          status = STAT_DEAD;
        end else begin
          status = STAT_OK;
        end

        if (status == STAT_OK) begin
          if (op_q == OP_LOOKUP || op_q == OP_PEEK || op_q == OP_REVOKE) begin
            res_obj = ent.tag;
          end
          if (op_q == OP_REMOVE || op_q == OP_REVOKE) begin
            wr_en          = 1'b1;
            wr_data.tag    = '0;
            wr_data.kind   = '0;
            wr_data.rights = '0;
            wr_data.gen    = ent.gen + GEN_BITS'(1);
            used_d[slot_a] = 1'b0;
            cnt_d          = cnt_q - COUNT_W'(1);
            res_gen        = wr_data.gen;
          end else if (op_q == OP_CLEAR_GRANT) begin
            wr_en          = 1'b1;
            wr_data.rights = ent.rights & ~grant_mask_q;
          end
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = S_EXEC;
      S_EXEC:  if (exec_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      written_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_go) begin
        used_q      <= used_d;
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
        if (wr_en) begin
          written_q[slot_a] <= 1'b1;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // slot memory
  always_ff @(posedge clk_i) begin
    if (exec_go && wr_en) begin
      mem[slot_a] <= wr_data;
    end
    if (in_acc) begin
      rd_q     <= mem[rd_addr];
      rd_hit_q <= written_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q       <= op_i;
      idx_q      <= slot_index_i;
      hspace_q   <= handle_space_i;
      hgen_q     <= handle_generation_i;
      tag_q      <= object_tag_i;
      kind_q     <= cap_kind_i;
      rights_q   <= rights_bits_i;
      live_q     <= object_live_i;
      free_idx_q <= free_idx;
      full_q     <= full;
    end
    if (exec_go) begin
      status_q         <= status;
      slot_out_q       <= res_slot;
      object_out_q     <= res_obj;
      generation_out_q <= res_gen;
      used_slots_q     <= cnt_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign slot_out_o       = slot_out_q;
  assign object_out_o     = object_out_q;
  assign generation_out_o = generation_out_q;
  assign used_slots_o     = used_slots_q;

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) == $countones(used_q))
    else $error("used count out of step with occupancy");

  a_used_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q & ~written_q) == '0)
    else $error("occupied slot never written");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_EXEC)
    else $error("accepted beat did not enter execute");

  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EXEC))
    else $error("result without execute cycle");

  a_occupancy_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> $stable(used_q) || $past(exec_go))
    else $error("occupancy changed outside write back");

endmodule

// File: bench/capability_slot_table_top_test.sv
`timescale 1ns / 1ps

module capability_slot_table_top_test;
  import capst_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_OPS      = 180;
  localparam int CHURN_OPS      = 32;

  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic [IDX_W-1:0]       idx;
    logic [SPACE_W-1:0]     hspace;
    logic [GEN_BITS-1:0]    hgen;
    logic [TAG_BITS-1:0]    tag;
    logic [KIND_W-1:0]      kind;
    logic [RIGHTS_BITS-1:0] rights;
    logic                   live;
  } table_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [TAG_BITS-1:0] obj;
    logic [GEN_BITS-1:0] gen;
    logic [COUNT_W-1:0]  used;
  } table_reply_t;

  class slot_table_checker;
    logic [SPACE_W-1:0]     space_id;
    logic [RIGHTS_BITS-1:0] grant_mask;
    bit                     slot_used   [SLOT_COUNT];
    logic [TAG_BITS-1:0]    slot_object [SLOT_COUNT];
    logic [KIND_W-1:0]      slot_kind   [SLOT_COUNT];
    logic [RIGHTS_BITS-1:0] slot_rights [SLOT_COUNT];
    logic [GEN_BITS-1:0]    gen_of_slot [SLOT_COUNT];
    int unsigned            used_count;
    table_reply_t           pending_replies[$];
    int                     errors;
    int                     n_ops;
    int                     n_replies;
    int                     status_hits[16];

    function new();
      space_id   = '0;
      grant_mask = RIGHT_GRANT_BIT;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_used[i]   = 1'b0;
        slot_object[i] = '0;
        slot_kind[i]   = '0;
        slot_rights[i] = '0;
        gen_of_slot[i] = '0;
      end
      used_count = 0;
      errors     = 0;
      n_ops      = 0;
      n_replies  = 0;
      for (int i = 0; i < 16; i++) status_hits[i] = 0;
    endfunction

    function void write_reg(reg_e r, logic [APB_DW-1:0] v);
      if (r == REG_SPACE_ID) space_id = v[SPACE_W-1:0];
      else grant_mask = v[RIGHTS_BITS-1:0];
    endfunction

    function void free_slot(logic [SLOT_W-1:0] s);
      slot_used[s]   = 1'b0;
      slot_object[s] = '0;
      slot_kind[s]   = '0;
      slot_rights[s] = '0;
      gen_of_slot[s] = gen_of_slot[s] + 1'b1;
      if (used_count > 0) used_count--;
    endfunction

    function int pick_used_slot();
      int start;
      int j;
      start = $urandom_range(SLOT_COUNT - 1);
      for (int k = 0; k < SLOT_COUNT; k++) begin
        j = (start + k) % SLOT_COUNT;
        if (slot_used[j]) return j;
      end
      return -1;
    endfunction

    function table_reply_t predict_reply(table_op_t t);
      table_reply_t r;
      logic [SLOT_W-1:0] s;
      bit handle_op;
      r = '0;
      r.status = STAT_OK;
      case (t.op)
        OP_INSTALL: begin
          if (t.kind == '0) r.status = STAT_WRONG_TYPE;
          else if (!t.live) r.status = STAT_DEAD;
          else begin
            r.status = STAT_FULL;
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (!slot_used[i] && r.status == STAT_FULL) begin
                slot_used[i]   = 1'b1;
                slot_object[i] = t.tag;
                slot_kind[i]   = t.kind;
                slot_rights[i] = t.rights;
                used_count++;
                r.status = STAT_OK;
                r.slot   = SLOT_W'(i);
                r.gen    = gen_of_slot[i];
              end
            end
          end
        end
        OP_REMOVE, OP_LOOKUP, OP_CLEAR_GRANT, OP_REVOKE, OP_PEEK: begin
          if (t.idx >= SLOT_COUNT) r.status = STAT_BAD_INDEX;
          else begin
            s = t.idx[SLOT_W-1:0];
            handle_op = (t.op == OP_LOOKUP) || (t.op == OP_REVOKE);
            r.slot = s;
            if (handle_op && t.hspace != space_id) r.status = STAT_WRONG_SPACE;
            else if (!slot_used[s]) r.status = STAT_EMPTY;
            else if (handle_op && t.hgen != gen_of_slot[s]) r.status = STAT_STALE;
            else if ((t.op == OP_LOOKUP || t.op == OP_PEEK) && slot_kind[s] != t.kind)
              r.status = STAT_WRONG_TYPE;
            else if (t.op == OP_LOOKUP && (slot_rights[s] & t.rights) != t.rights)
              r.status = STAT_RIGHTS;
            else if (t.op == OP_LOOKUP && !t.live) r.status = STAT_DEAD;
            if (r.status == STAT_OK) begin
              case (t.op)
                OP_REMOVE: free_slot(s);
                OP_CLEAR_GRANT: slot_rights[s] = slot_rights[s] & ~grant_mask;
                OP_REVOKE: begin
                  r.obj = slot_object[s];
                  free_slot(s);
                end
                default: r.obj = slot_object[s];
              endcase
            end
            r.gen = gen_of_slot[s];
          end
        end
        default: ;
      endcase
      r.used = COUNT_W'(used_count);
      return r;
    endfunction

    function void note_op(table_op_t t);
      pending_replies.push_back(predict_reply(t));
      n_ops++;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at reply %0d: %s", n_replies, msg);
      errors++;
    endtask

    task check_reply(table_reply_t got);
      table_reply_t want;
      if (pending_replies.size() == 0) begin
        report_mismatch("reply with no op outstanding");
        return;
      end
      want = pending_replies.pop_front();
      status_hits[want.status]++;
      if (got.status != want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.slot != want.slot)
        report_mismatch($sformatf("slot %0d, want %0d", got.slot, want.slot));
      if (got.obj != want.obj)
        report_mismatch($sformatf("object %h, want %h", got.obj, want.obj));
      if (got.gen != want.gen)
        report_mismatch($sformatf("generation %h, want %h", got.gen, want.gen));
      if (got.used != want.used)
        report_mismatch($sformatf("used slots %0d, want %0d", got.used, want.used));
      n_replies++;
    endtask
  endclass

  logic                   clk_i;
  logic                   rst_ni              = 1'b0;
  logic                   in_valid_i          = 1'b0;
  logic                   in_stall_o;
  logic [OP_W-1:0]        op_i                = '0;
  logic [IDX_W-1:0]       slot_index_i        = '0;
  logic [SPACE_W-1:0]     handle_space_i      = '0;
  logic [GEN_BITS-1:0]    handle_generation_i = '0;
  logic [TAG_BITS-1:0]    object_tag_i        = '0;
  logic [KIND_W-1:0]      cap_kind_i          = '0;
  logic [RIGHTS_BITS-1:0] rights_bits_i       = '0;
  logic                   object_live_i       = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i         = 1'b0;
  logic [STATUS_W-1:0]    status_o;
  logic [SLOT_W-1:0]      slot_out_o;
  logic [TAG_BITS-1:0]    object_out_o;
  logic [GEN_BITS-1:0]    generation_out_o;
  logic [COUNT_W-1:0]     used_slots_o;
  logic                   psel                = 1'b0;
  logic                   penable             = 1'b0;
  logic                   pwrite              = 1'b0;
  logic [APB_AW-1:0]      paddr               = '0;
  logic [APB_DW-1:0]      pwdata              = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  slot_table_checker sb;
  table_reply_t      seen;
  int                idle_pct      = 38;
  int                quiet_cycles  = 0;
  int                settings_done = 0;

  capability_slot_table_top uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .op_i                (op_i),
    .slot_index_i        (slot_index_i),
    .handle_space_i      (handle_space_i),
    .handle_generation_i (handle_generation_i),
    .object_tag_i        (object_tag_i),
    .cap_kind_i          (cap_kind_i),
    .rights_bits_i       (rights_bits_i),
    .object_live_i       (object_live_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .slot_out_o          (slot_out_o),
    .object_out_o        (object_out_o),
    .generation_out_o    (generation_out_o),
    .used_slots_o        (used_slots_o),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_stall_i <= ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen.status = status_o;
        seen.slot   = slot_out_o;
        seen.obj    = object_out_o;
        seen.gen    = generation_out_o;
        seen.used   = used_slots_o;
        sb.check_reply(seen);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                         input logic [SPACE_W-1:0] hspace, input logic [GEN_BITS-1:0] hgen,
                         input logic [TAG_BITS-1:0] tag, input logic [KIND_W-1:0] kind,
                         input logic [RIGHTS_BITS-1:0] rights, input logic live);
    table_op_t t;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    op_i                <= op;
    slot_index_i        <= idx;
    handle_space_i      <= hspace;
    handle_generation_i <= hgen;
    object_tag_i        <= tag;
    cap_kind_i          <= kind;
    rights_bits_i       <= rights;
    object_live_i       <= live;
    in_valid_i          <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    t.op     = op;
    t.idx    = idx;
    t.hspace = hspace;
    t.hgen   = hgen;
    t.tag    = tag;
    t.kind   = kind;
    t.rights = rights;
    t.live   = live;
    sb.note_op(t);
  endtask

  task automatic send_random_op(input int inst_pct);
    int pick;
    int found;
    logic [OP_W-1:0]        op;
    logic [IDX_W-1:0]       idx;
    logic [SPACE_W-1:0]     hspace;
    logic [GEN_BITS-1:0]    hgen;
    logic [TAG_BITS-1:0]    tag;
    logic [KIND_W-1:0]      kind;
    logic [RIGHTS_BITS-1:0] rights;
    logic                   live;
    logic [SLOT_W-1:0]      s;
    tag    = TAG_BITS'($urandom_range(16'hFFFF));
    hspace = SPACE_W'($urandom_range(16'hFFFF));
    hgen   = GEN_BITS'($urandom_range(16'hFFFF));
    kind   = KIND_W'($urandom_range(15));
    rights = RIGHTS_BITS'($urandom_range(255));
    live   = ($urandom_range(99) < 92);
    idx    = IDX_W'($urandom_range(127));
    if ($urandom_range(99) < inst_pct) begin
      op = OP_INSTALL;
      if ($urandom_range(99) >= 6) kind = KIND_W'($urandom_range(15, 1));
    end else begin
      pick = $urandom_range(99);
      if (pick < 14) op = OP_REMOVE;
      else if (pick < 44) op = OP_LOOKUP;
      else if (pick < 56) op = OP_CLEAR_GRANT;
      else if (pick < 72) op = OP_REVOKE;
      else if (pick < 95) op = OP_PEEK;
      else op = $urandom_range(1) ? OP_UNUSED_HI : OP_UNUSED_LO;
      pick  = $urandom_range(99);
      found = sb.pick_used_slot();
      if (pick < 75 && found >= 0) idx = IDX_W'(found);
      else if (pick < 92) idx = IDX_W'($urandom_range(SLOT_COUNT - 1));
      else idx = IDX_W'($urandom_range(127, SLOT_COUNT));
      if (idx < SLOT_COUNT) begin
        s = idx[SLOT_W-1:0];
        if ($urandom_range(99) < 88) hspace = sb.space_id;
        pick = $urandom_range(99);
        if (pick < 85) hgen = sb.gen_of_slot[s];
        else if (pick < 92) hgen = sb.gen_of_slot[s] - 1'b1;
        if ($urandom_range(99) < 85) kind = sb.slot_kind[s];
        if ($urandom_range(99) < 75) rights = sb.slot_rights[s] & rights;
      end
    end
    send_op(op, idx, hspace, hgen, tag, kind, rights, live);
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input reg_e r, input logic [APB_DW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(r, v);
  endtask

  initial begin
    logic [SPACE_W-1:0]     sp;
    logic [RIGHTS_BITS-1:0] gm;
    int inst;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: space 0, grant mask = grant right
    send_op(OP_INSTALL, 7'd0, 16'h0000, 16'h0000, 16'h1111, 4'd0, 8'hFF, 1'b1);
    send_op(OP_INSTALL, 7'd0, 16'h0000, 16'h0000, 16'h2222, 4'd3, 8'hFF, 1'b0);
    send_op(OP_INSTALL, 7'd127, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 8'hFF, 1'b1);
    send_op(OP_INSTALL, 7'd0, 16'h0000, 16'h0000, 16'h0000, 4'd1, 8'h01, 1'b1);
    send_op(OP_LOOKUP, 7'd0, 16'h0000, 16'h0000, 16'h0000, 4'hF, 8'hFF, 1'b1);
    send_op(OP_LOOKUP, 7'd127, 16'h0000, 16'h0000, 16'h0000, 4'hF, 8'h00, 1'b1);
    send_op(OP_LOOKUP, 7'd64, 16'h0000, 16'h0000, 16'h0000, 4'hF, 8'h00, 1'b1);
    send_op(OP_LOOKUP, 7'd0, 16'hFFFF, 16'h0000, 16'h0000, 4'hF, 8'h00, 1'b1);
    send_op(OP_LOOKUP, 7'd5, 16'h0000, 16'h0000, 16'h0000, 4'hF, 8'h00, 1'b1);
    send_op(OP_LOOKUP, 7'd0, 16'h0000, 16'hFFFF, 16'h0000, 4'hF, 8'h00, 1'b1);
    send_op(OP_LOOKUP, 7'd0, 16'h0000, 16'h0000, 16'h0000, 4'd1, 8'h00, 1'b1);
    send_op(OP_LOOKUP, 7'd1, 16'h0000, 16'h0000, 16'h0000, 4'd1, 8'h02, 1'b1);
    send_op(OP_LOOKUP, 7'd0, 16'h0000, 16'h0000, 16'h0000, 4'hF, 8'h00, 1'b0);
    send_op(OP_CLEAR_GRANT, 7'd1, 16'h0000, 16'h0000, 16'h0000, 4'd0, 8'h00, 1'b1);
    send_op(OP_LOOKUP, 7'd1, 16'h0000, 16'h0000, 16'h0000, 4'd1, 8'h01, 1'b1);
    send_op(OP_CLEAR_GRANT, 7'd9, 16'h0000, 16'h0000, 16'h0000, 4'd0, 8'h00, 1'b1);
    send_op(OP_PEEK, 7'd1, 16'h0000, 16'h0000, 16'h0000, 4'd1, 8'h00, 1'b1);
    send_op(OP_PEEK, 7'd1, 16'h0000, 16'h0000, 16'h0000, 4'd2, 8'h00, 1'b1);
    send_op(OP_REVOKE, 7'd1, 16'h0000, 16'h0000, 16'h0000, 4'd0, 8'h00, 1'b1);
    send_op(OP_REVOKE, 7'd0, 16'h0000, 16'h0001, 16'h0000, 4'd0, 8'h00, 1'b1);
    send_op(OP_REMOVE, 7'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0, 8'h00, 1'b1);
    send_op(OP_REMOVE, 7'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0, 8'h00, 1'b1);
    send_op(OP_REMOVE, 7'd100, 16'h0000, 16'h0000, 16'h0000, 4'd0, 8'h00, 1'b1);
    send_op(OP_UNUSED_LO, 7'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 8'hFF, 1'b1);
    send_op(OP_UNUSED_HI, 7'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0, 8'h00, 1'b0);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          sp = 16'h0000; gm = 8'h01; inst = 55; idle_pct = 38;
        end
        1: begin
          sp = 16'hFFFF; gm = 8'hFF; inst = 70; idle_pct = 38;
        end
        2: begin
          sp = SPACE_W'($urandom_range(16'hFFFF)); gm = 8'h00; inst = 30; idle_pct = 0;
        end
        3: begin
          sp = 16'h8001; gm = RIGHTS_BITS'($urandom_range(255)); inst = 20; idle_pct = 38;
        end
        4: begin
          sp = SPACE_W'($urandom_range(16'hFFFF)); gm = RIGHTS_BITS'($urandom_range(255));
          inst = 50; idle_pct = 38;
        end
        default: begin
          sp = 16'h5A5A; gm = 8'h81; inst = 65; idle_pct = 38;
        end
      endcase
      wait_quiet();
      reg_write(REG_SPACE_ID, {16'h0000, sp});
      reg_write(REG_GRANT_MASK, {24'h000000, gm});
      settings_done++;
      repeat (PHASE_OPS) send_random_op(inst);
    end

    // churn slot 0 through install and revoke, back to back
    wait_quiet();
    idle_pct = 0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (sb.slot_used[i])
        send_op(OP_REMOVE, IDX_W'(i), 16'h0000, 16'h0000, 16'h0000, 4'd0, 8'h00, 1'b1);
    end
    for (int k = 0; k < CHURN_OPS; k++) begin
      send_op(OP_INSTALL, IDX_W'($urandom_range(127)), SPACE_W'($urandom_range(16'hFFFF)),
              GEN_BITS'($urandom_range(16'hFFFF)), TAG_BITS'($urandom_range(16'hFFFF)),
              KIND_W'($urandom_range(15, 1)), RIGHTS_BITS'($urandom_range(255)), 1'b1);
      send_op(OP_REVOKE, 7'd0, sb.space_id, sb.gen_of_slot[0],
              TAG_BITS'($urandom_range(16'hFFFF)), KIND_W'($urandom_range(15)),
              RIGHTS_BITS'($urandom_range(255)), 1'($urandom_range(1)));
    end
    idle_pct = 38;
    repeat (40) send_random_op(50);

    wait_quiet();
    $display("%0d table ops, %0d replies checked, %0d register settings, slot 0 churned",
             sb.n_ops, sb.n_replies, settings_done);
    $display("status mix: ok %0d badidx %0d space %0d empty %0d stale %0d type %0d %s %0d",
             sb.status_hits[STAT_OK], sb.status_hits[STAT_BAD_INDEX],
             sb.status_hits[STAT_WRONG_SPACE], sb.status_hits[STAT_EMPTY],
             sb.status_hits[STAT_STALE], sb.status_hits[STAT_WRONG_TYPE],
             $sformatf("rights %0d dead %0d full", sb.status_hits[STAT_RIGHTS],
                       sb.status_hits[STAT_DEAD]),
             sb.status_hits[STAT_FULL]);
    if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/capst_pkg.sv
hdl/capability_slot_table_top.sv
bench/capability_slot_table_top_test.sv
